// ----- rtl/b64d_pkg.sv -----
// Shared types, constants and the character map for the base64 stream decoder.
// No dependencies; every other file in rtl uses this package by scoped names.
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned RES_SLOTS = 4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_PAD = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
        logic [1:0] status;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic [2:0]                cnt;
        t_out [RES_SLOTS-1:0]      items;
    } t_res_set;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } t_sextet;

    // Maps one character to its sextet. The pad character maps to zero and
    // counts as valid; characters outside the alphabet are flagged not ok.
    function automatic t_sextet map_char(input logic [7:0] c);
        t_sextet r;
        r.ok    = 1'b1;
        r.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 6'(c - 8'd65);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 6'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c + 8'd4);
        end else if (c == 8'h2B) begin
            r.value = 6'd62;
        end else if (c == 8'h2F) begin
            r.value = 6'd63;
        end else if (c == PAD_CHAR) begin
            r.value = 6'd0;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/b64d_obuf.sv -----
// Four-slot output buffer that is loaded with a whole result set at once and
// drains one result per transaction. Depends on b64d_pkg.
module b64d_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  b64d_pkg::t_res_set i_set,
    output logic               o_can_load,
    output logic               o_valid,
    output b64d_pkg::t_out     o_res,
    input  logic               i_stall
);

    b64d_pkg::t_out r_slot [b64d_pkg::RES_SLOTS];
    logic [2:0]     r_cnt;
    logic           pop;

    assign pop        = (r_cnt != 3'd0) && !i_stall;
    assign o_can_load = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && pop);
    assign o_valid    = (r_cnt != 3'd0);
    assign o_res      = r_slot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_set.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < b64d_pkg::RES_SLOTS; k++) begin
                r_slot[k] <= i_set.items[k];
            end
        end else if (pop) begin
            for (int k = 0; k < b64d_pkg::RES_SLOTS - 1; k++) begin
                r_slot[k] <= r_slot[k+1];
            end
        end
    end

endmodule

// ----- rtl/base64_stream_decoder_core.sv -----
// Base64 stream decoder top level: input register, decode state and logic,
// and the output buffer. Depends on b64d_pkg and b64d_obuf.
//
// The block takes one character per cycle while o_stall is low. A character
// is held in the input register, where it is mapped and folded into the
// group state. A character that completes a group or ends the text hands up
// to four results (three bytes and the end item) to a four-slot output buffer
// that drains one result per cycle while i_stall is low; such a character
// waits in the input register until the buffer is empty or empties in that
// same cycle, so later characters wait behind it. Results pass the input
// register and then the output buffer slots. Other characters never wait.
module base64_stream_decoder_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  b64d_pkg::t_in   i_in,
    output logic            o_stall,
    output logic            o_valid,
    output b64d_pkg::t_out  o_res,
    input  logic            i_stall
);

    logic             r_in_vld;
    b64d_pkg::t_in    r_in;
    logic [5:0]       r_sx [3];
    logic [1:0]       r_pos;
    logic [2:0]       r_pad;
    logic             r_stop;
    logic [1:0]       r_vcnt;
    logic             r_any;
    logic             r_perr;

    logic [5:0]       n_sx [3];
    logic [1:0]       n_pos;
    logic [2:0]       n_pad;
    logic             n_stop;
    logic [1:0]       n_vcnt;
    logic             n_any;
    logic             n_perr;

    b64d_pkg::t_sextet  sx;
    logic               is_pad;
    logic [2:0]         nbytes;
    logic [2:0]         nres;
    logic [7:0]         bytes [3];
    logic [1:0]         st;
    b64d_pkg::t_res_set res_set;
    logic               can_load;
    logic               produce;
    logic               adv;
    logic               in_take;

    assign sx     = b64d_pkg::map_char(r_in.char_code);
    assign is_pad = (r_in.char_code == b64d_pkg::PAD_CHAR);

    assign bytes[0] = {r_sx[0], r_sx[1][5:4]};
    assign bytes[1] = {r_sx[1][3:0], r_sx[2][5:2]};
    assign bytes[2] = {r_sx[2][1:0], sx.value};

    always_comb begin
        n_sx   = r_sx;
        n_pos  = r_pos;
        n_pad  = r_pad;
        n_stop = r_stop;
        n_vcnt = r_vcnt;
        n_any  = r_any;
        n_perr = r_perr;
        nbytes = 3'd0;
        if (sx.ok) begin
            n_vcnt = r_vcnt + 2'd1;
            n_any  = 1'b1;
            if (!r_stop) begin
                if (is_pad && (r_pad != 3'd7)) begin
                    n_pad = r_pad + 3'd1;
                end
                if (r_pos != 2'd3) begin
                    n_sx[r_pos] = sx.value;
                    n_pos       = r_pos + 2'd1;
                end else begin
                    case (n_pad)
                        3'd0: begin
                            nbytes = 3'd3;
                        end
                        3'd1: begin
                            nbytes = 3'd2;
                        end
                        3'd2: begin
                            nbytes = 3'd1;
                        end
                        default: begin
                            nbytes = 3'd0;
                            n_perr = 1'b1;
                        end
                    endcase
                    if (n_pad != 3'd0) begin
                        n_stop = 1'b1;
                    end
                    n_pos = 2'd0;
                end
            end
        end

        if (!n_any || (n_vcnt != 2'd0)) begin
            st = b64d_pkg::ST_BAD_LEN;
        end else if (n_perr) begin
            st = b64d_pkg::ST_BAD_PAD;
        end else begin
            st = b64d_pkg::ST_OK;
        end

        nres = nbytes + {2'd0, r_in.last_char};

        for (int k = 0; k < 3; k++) begin
            res_set.items[k] = '0;
            if (nbytes > 3'(k)) begin
                res_set.items[k].data_byte = bytes[k];
            end else if ((nbytes == 3'(k)) && r_in.last_char) begin
                res_set.items[k].is_end = 1'b1;
                res_set.items[k].status = st;
            end
            res_set.items[k].run_last = (nres == 3'(k + 1));
        end
        res_set.items[3] = '0;
        if ((nbytes == 3'd3) && r_in.last_char) begin
            res_set.items[3].is_end = 1'b1;
            res_set.items[3].status = st;
        end
        res_set.items[3].run_last = (nres == 3'd4);
        res_set.cnt = nres;

        if (r_in.last_char) begin
            for (int k = 0; k < 3; k++) begin
                n_sx[k] = 6'd0;
            end
            n_pos  = 2'd0;
            n_pad  = 3'd0;
            n_stop = 1'b0;
            n_vcnt = 2'd0;
            n_any  = 1'b0;
            n_perr = 1'b0;
        end
    end

    assign produce = r_in_vld && (nres != 3'd0);
    assign adv     = r_in_vld && (!produce || can_load);
    assign o_stall = r_in_vld && !adv;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_sx[k] <= 6'd0;
            end
            r_pos  <= 2'd0;
            r_pad  <= 3'd0;
            r_stop <= 1'b0;
            r_vcnt <= 2'd0;
            r_any  <= 1'b0;
            r_perr <= 1'b0;
        end else if (adv) begin
            r_sx   <= n_sx;
            r_pos  <= n_pos;
            r_pad  <= n_pad;
            r_stop <= n_stop;
            r_vcnt <= n_vcnt;
            r_any  <= n_any;
            r_perr <= n_perr;
        end
    end

    b64d_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (produce && can_load),
        .i_set      (res_set),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_stall    (i_stall)
    );

`ifndef SYNTHESIS
    // The end item is always the final result of its transaction.
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.is_end) |-> o_res.run_last)
        else $error("end item without run_last");

    // Data bytes never carry a status.
    a_data_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.is_end) |-> (o_res.status == b64d_pkg::ST_OK))
        else $error("data byte with nonzero status");

    // Decoding only stops after a group that held a pad mark.
    a_stop_has_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |-> (r_pad != 3'd0))
        else $error("decoding stopped without pad marks");

    // Consuming the last character returns the stream state to reset.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.last_char) |=> ((r_pos == 2'd0) && !r_any && !r_perr && !r_stop))
        else $error("stream state not cleared after last character");
`endif

endmodule
